### hw/rtl/fncf_pkg.sv
// Shared constants for the fractional noise coloring filter.
// Used by the multiplier, the divider and the top level; no dependencies.
package fncf_pkg;

  localparam int Taps    = 64;
  localparam int TapW    = $clog2(Taps);
  localparam int CntW    = $clog2(Taps + 1);

  localparam int SampW   = 16;
  localparam int CoefW   = 18;
  localparam int AlphaW  = 15;
  localparam int OutW    = 17;

  localparam int MulAW   = CoefW + 1;
  localparam int NumW    = TapW + 16;
  localparam int ProdW   = MulAW + NumW;
  localparam int DivNW   = ProdW - 15;
  localparam int DivCntW = $clog2(DivNW);
  localparam int AccW    = CoefW + SampW + TapW;

  localparam int InTdataW  = 16;
  localparam int OutTdataW = 24;

  typedef logic signed [MulAW-1:0] mul_a_t;
  typedef logic signed [NumW-1:0]  mul_b_t;
  typedef logic signed [ProdW-1:0] mul_p_t;

endpackage

### hw/rtl/fncf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on fncf_pkg for operand and product types.
module fncf_mul import fncf_pkg::*; (
  input  logic   clk_i,
  input  mul_a_t a_i,
  input  mul_b_t b_i,
  output mul_p_t p_o
);

  mul_p_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

### hw/rtl/fncf_div.sv
// Restoring divider, one quotient bit per cycle, for the coefficient recursion.
// Depends on fncf_pkg for widths.
module fncf_div import fncf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] dividend_i,
  input  logic [TapW-1:0]  divisor_i,
  output logic             done_o,
  output logic [DivNW-1:0] quotient_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [TapW-1:0]    rem_q, rem_d;
  logic [DivNW-1:0]   quo_q, quo_d;
  logic [TapW:0]      rem_sh;
  logic               ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DivNW-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? TapW'(rem_sh - {1'b0, divisor_i}) : rem_sh[TapW-1:0];
      quo_d = {quo_q[DivNW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hw/rtl/fractional_noise_coloring_filter.sv
// Fractional noise coloring filter: 64-tap FIR on one shared multiplier.
// Warm-up word: accepted, no result. Filtered word: taps are read, multiplied and
// summed (one product per tap); the rounded, saturated sum waits for a free output
// register; input is ready again as the result goes valid. After reset and after
// each alpha write the bit-serial divider rebuilds the coefficient table; input
// is not ready meanwhile. Reset is asynchronous, active low, alpha = 0.5.
module fractional_noise_coloring_filter import fncf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [AlphaW-1:0]    cfg_wdata_i,   // alpha[14:0]
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // white_sample[15:0]
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,  // colored_sample[16:0], zero pad
  output logic                 m_axis_tlast
);

  localparam logic [2:0] S_CINIT = 3'd0;
  localparam logic [2:0] S_CMUL  = 3'd1;
  localparam logic [2:0] S_CRND  = 3'd2;
  localparam logic [2:0] S_CDIV  = 3'd3;
  localparam logic [2:0] S_IDLE  = 3'd4;
  localparam logic [2:0] S_FIR   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [AlphaW-1:0]       alpha_q, alpha_d;
  logic [TapW-1:0]         k_q, k_d;
  logic signed [MulAW-1:0] prev_q, prev_d;
  logic                    sign_q, sign_d;
  logic [TapW-1:0]         wp_q, wp_d;
  logic [CntW-1:0]         warm_q, warm_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    rd_vld_q, rd_vld_d;
  logic                    mul_vld_q, mul_vld_d;
  logic                    last_q, last_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    out_vld_q, out_vld_d;
  logic [OutW-1:0]         out_data_q;
  logic                    out_last_q;
  logic                    out_load;

  logic [CoefW-1:0] coef_mem [Taps];
  logic [SampW-1:0] hist_mem [Taps];
  logic [CoefW-1:0] coef_rd_q;
  logic [SampW-1:0] hist_rd_q;
  logic             cwe;
  logic [TapW-1:0]  cwaddr;
  logic [CoefW-1:0] cwdata;
  logic             hwe;
  logic [TapW-1:0]  caddr, haddr;
  logic [TapW:0]    hdiff, hwrap;

  mul_a_t mul_a;
  mul_b_t mul_b;
  mul_p_t mul_p;
  mul_b_t num;
  logic [TapW-1:0]   k_m1;
  logic              p_neg;
  logic [ProdW-1:0]  mag, rnd;
  logic              div_start, div_done;
  logic [DivNW-1:0]  div_quo;
  logic [CoefW-1:0]  qv;
  logic signed [MulAW-1:0] prev_n;
  logic [TapW-1:0]   wp_n;
  logic              in_acc;
  logic signed [AccW-1:0] rsum, rsh;
  logic [OutW-1:0]   out_sat;

  function automatic logic [CoefW-1:0] sat_coef(input logic signed [MulAW-1:0] v);
    logic [CoefW-1:0] r;
    if (v[MulAW-1] != v[MulAW-2]) begin
      r = v[MulAW-1] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      r = v[CoefW-1:0];
    end
    return r;
  endfunction

  fncf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  fncf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd[ProdW-1:15]),
    .divisor_i  (k_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    k_m1  = k_q - 1'b1;
    num   = $signed({1'b0, k_m1, 15'd0}) - $signed({{(NumW-AlphaW){1'b0}}, alpha_q});
    p_neg = mul_p[ProdW-1];
    mag   = p_neg ? ProdW'(-mul_p) : ProdW'(mul_p);
    rnd   = mag + {{(ProdW-TapW-14){1'b0}}, k_q, 14'd0};
    qv    = div_quo[CoefW-1:0];
    prev_n = sign_q ? -$signed({1'b0, qv}) : $signed({1'b0, qv});

    if (state_q == S_CMUL) begin
      mul_a = prev_q;
      mul_b = num;
    end else begin
      mul_a = {coef_rd_q[CoefW-1], coef_rd_q};
      mul_b = {{(NumW-SampW){hist_rd_q[SampW-1]}}, hist_rd_q};
    end

    caddr = cnt_q[TapW-1:0];
    hdiff = {1'b0, wp_q} - {1'b0, cnt_q[TapW-1:0]};
    hwrap = hdiff + (TapW+1)'(Taps);
    haddr = hdiff[TapW] ? hwrap[TapW-1:0] : hdiff[TapW-1:0];

    wp_n   = (wp_q == TapW'(Taps - 1)) ? '0 : wp_q + 1'b1;
    in_acc = s_axis_tvalid && s_axis_tready;

    rsum = acc_q + AccW'(65536);
    rsh  = rsum >>> 17;
    if ((&rsh[AccW-1:OutW-1]) || !(|rsh[AccW-1:OutW-1])) begin
      out_sat = rsh[OutW-1:0];
    end else begin
      out_sat = rsh[AccW-1] ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign hwe = in_acc;

  always_comb begin
    state_d   = state_q;
    alpha_d   = alpha_q;
    k_d       = k_q;
    prev_d    = prev_q;
    sign_d    = sign_q;
    wp_d      = wp_q;
    warm_d    = warm_q;
    cnt_d     = cnt_q;
    rd_vld_d  = 1'b0;
    mul_vld_d = rd_vld_q;
    last_d    = last_q;
    acc_d     = acc_q;
    out_load  = 1'b0;
    div_start = 1'b0;
    cwe       = 1'b0;
    cwaddr    = k_q;
    cwdata    = sat_coef(prev_n);

    case (state_q)
      S_CINIT: begin
        cwe     = 1'b1;
        cwaddr  = '0;
        cwdata  = {1'b0, {(CoefW-1){1'b1}}};
        k_d     = TapW'(1);
        prev_d  = $signed({2'b01, {(MulAW-2){1'b0}}});
        state_d = S_CMUL;
      end
      S_CMUL: begin
        state_d = S_CRND;
      end
      S_CRND: begin
        sign_d    = p_neg;
        div_start = 1'b1;
        state_d   = S_CDIV;
      end
      S_CDIV: begin
        if (div_done) begin
          cwe    = 1'b1;
          prev_d = prev_n;
          if (k_q == TapW'(Taps - 1)) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_CMUL;
          end
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          wp_d = wp_n;
          if (warm_q < CntW'(Taps)) begin
            warm_d = warm_q + 1'b1;
            if (s_axis_tlast) begin
              warm_d = '0;
              wp_d   = '0;
            end
          end else begin
            last_d  = s_axis_tlast;
            cnt_d   = '0;
            acc_d   = '0;
            state_d = S_FIR;
          end
        end
      end
      S_FIR: begin
        if (cnt_q < CntW'(Taps)) begin
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end else if (!rd_vld_q && !mul_vld_q) begin
          state_d = S_OUT;
        end
        if (mul_vld_q) begin
          acc_d = acc_q + mul_p[AccW-1:0];
        end
      end
      S_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          if (last_q) begin
            warm_d = '0;
            wp_d   = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CINIT;
      end
    endcase

    if (cfg_we_i) begin
      alpha_d = cfg_wdata_i;
      state_d = S_CINIT;
    end

    out_vld_d = (out_vld_q && !m_axis_tready) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CINIT;
      alpha_q   <= AlphaW'(16384);
      k_q       <= '0;
      wp_q      <= '0;
      warm_q    <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      alpha_q   <= alpha_d;
      k_q       <= k_d;
      wp_q      <= wp_d;
      warm_q    <= warm_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      mul_vld_q <= mul_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    sign_q <= sign_d;
    last_q <= last_d;
    acc_q  <= acc_d;
    if (out_load) begin
      out_data_q <= out_sat;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cwe) begin
      coef_mem[cwaddr] <= cwdata;
    end
    coef_rd_q <= coef_mem[caddr];
  end

  always_ff @(posedge clk_i) begin
    if (hwe) begin
      hist_mem[wp_n] <= s_axis_tdata[SampW-1:0];
    end
    hist_rd_q <= hist_mem[haddr];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutTdataW-OutW){1'b0}}, out_data_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### tb/sv/fractional_noise_coloring_filter_checker.sv
// Checker for the fractional noise coloring filter: tracks alpha, the tap table
// and the sample history, predicts each colored word and compares it on output.
// Depends on fncf_pkg for widths and the tap count.
module fractional_noise_coloring_filter_checker import fncf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [AlphaW-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // white_sample[15:0]
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutTdataW-1:0] m_axis_tdata,   // colored_sample[16:0], zero pad
  input  logic                 m_axis_tlast,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam logic [AlphaW-1:0] AlphaReset = 15'd16384;
  localparam longint CoefOne  = 131072;
  localparam longint CoefMax  = 131071;
  localparam longint CoefMin  = -131072;
  localparam longint OutMax   = 65535;
  localparam longint OutMin   = -65536;
  localparam longint RoundHalf = 65536;
  localparam int     MaxReports = 10;

  typedef struct {
    logic signed [OutW-1:0] sample;
    logic                   last;
  } colored_word_t;

  logic [AlphaW-1:0]       alpha_q;
  logic signed [CoefW-1:0] coef_q [Taps];
  logic signed [SampW-1:0] history_q [Taps];
  int unsigned             warmup_q;
  int unsigned             wr_ptr_q;
  colored_word_t           colored_due [$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic rebuild_coefs();
    longint prev, num, prod, div, mag, quo;
    prev = CoefOne;
    coef_q[0] = CoefW'(clamp(prev, CoefMin, CoefMax));
    for (int k = 1; k < Taps; k++) begin
      num  = longint'(k - 1) * 32768 - longint'(alpha_q);
      prod = prev * num;
      div  = longint'(k) * 32768;
      mag  = (prod < 0) ? -prod : prod;
      quo  = (mag + div / 2) / div;
      prev = (prod < 0) ? -quo : quo;
      coef_q[k] = CoefW'(clamp(prev, CoefMin, CoefMax));
    end
  endtask

  task automatic clear_run();
    for (int i = 0; i < Taps; i++) history_q[i] = '0;
    warmup_q = 0;
    wr_ptr_q = 0;
  endtask

  task automatic take_sample(input logic signed [SampW-1:0] x, input logic last);
    longint        acc;
    colored_word_t w;
    wr_ptr_q = (wr_ptr_q + 1) % Taps;
    history_q[wr_ptr_q] = x;
    if (warmup_q < Taps) begin
      warmup_q++;
    end else begin
      acc = 0;
      for (int j = 0; j < Taps; j++) begin
        acc += longint'(coef_q[j]) * longint'(history_q[(wr_ptr_q + Taps - j) % Taps]);
      end
      w.sample = OutW'(clamp((acc + RoundHalf) >>> 17, OutMin, OutMax));
      w.last   = last;
      colored_due.push_back(w);
    end
    if (last) clear_run();
  endtask

  task automatic check_word();
    colored_word_t w;
    if (colored_due.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MaxReports) begin
        $display("mismatch: unexpected word sample=%0d last=%0b",
                 $signed(m_axis_tdata[OutW-1:0]), m_axis_tlast);
      end
    end else begin
      w = colored_due.pop_front();
      if (m_axis_tdata[OutW-1:0] !== w.sample || m_axis_tlast !== w.last) begin
        fail_count_o++;
        if (fail_count_o <= MaxReports) begin
          $display("mismatch: expected sample=%0d last=%0b, got sample=%0d last=%0b",
                   w.sample, w.last, $signed(m_axis_tdata[OutW-1:0]), m_axis_tlast);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q = AlphaReset;
      rebuild_coefs();
      clear_run();
      colored_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        alpha_q = cfg_wdata_i;
        rebuild_coefs();
      end
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (s_axis_tvalid && s_axis_tready) begin
        take_sample($signed(s_axis_tdata[SampW-1:0]), s_axis_tlast);
      end
    end
    pending_o = colored_due.size();
  end

endmodule

### tb/sv/fractional_noise_coloring_filter_tb.sv
// Testbench top for the fractional noise coloring filter: clock, reset, word
// source and sink with random gaps, alpha phases, watchdog and verdict.
// Depends on fncf_pkg, the filter RTL and fractional_noise_coloring_filter_checker.
module fractional_noise_coloring_filter_tb import fncf_pkg::*;;

  localparam int StallLimit  = 10000;
  localparam int HoldCycles  = 600;
  localparam int SettleWait  = 80;
  localparam int DrainWait   = 100;
  localparam int PhaseWords  = 140;
  localparam int Phases      = 6;
  localparam int Probes      = 13;
  localparam logic [SampW-1:0] PosMax = 16'h7FFF;
  localparam logic [SampW-1:0] NegMax = 16'h8000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [AlphaW-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  int fail_count;
  int pending;
  int idle_pct;
  int words_sent;
  int hold_left;
  int gap_left;
  int quiet_cycles;
  bit stall_req;
  bit hold_done;

  fractional_noise_coloring_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  fractional_noise_coloring_filter_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // sink: random gaps, one long hold on request
  initial begin
    hold_left = 0;
    gap_left  = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        gap_left = $urandom_range(12, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [SampW-1:0] data, input logic last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_extremes(input int count);
    for (int i = 0; i < count; i++) begin
      send_word((i % 2) ? NegMax : PosMax, i == count - 1);
    end
  endtask

  function automatic logic [SampW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return PosMax;
      1:       return NegMax;
      2:       return '0;
      default: return SampW'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(Taps - 1, 1);
      2:       return $urandom_range(Taps + 1, Taps);
      default: return $urandom_range(160, Taps + 1);
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_word(pick_sample(), i == len - 1);
  endtask

  // drain, let the last warm-up word settle, then write alpha
  task automatic write_alpha(input logic [AlphaW-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SettleWait) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [SampW-1:0]  probe [Probes];
    logic [AlphaW-1:0] phase_alpha [Phases];
    int                phase_idle [Phases];
    int                phase_start;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    idle_pct      = 0;
    words_sent    = 0;
    stall_req     = 1'b0;

    probe = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF,
              16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000};
    phase_alpha = '{15'h7FFF, 15'h0000, 15'h0001, 15'h7FFE,
                    AlphaW'($urandom), AlphaW'($urandom)};
    phase_idle  = '{25, 50, 0, 25, 10, 0};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset alpha: last inside warm-up, then full history of extremes and probes
    idle_pct = 20;
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h1234, 1'b1);
    for (int i = 0; i < Taps; i++) send_word((i % 2) ? NegMax : PosMax, 1'b0);
    for (int i = 0; i < Probes; i++) send_word(probe[i], i == Probes - 1);

    for (int p = 0; p < Phases; p++) begin
      write_alpha(phase_alpha[p]);
      idle_pct    = phase_idle[p];
      phase_start = words_sent;
      if (p == 0) send_extremes(Taps + 20);
      if (p == 1) begin
        stall_req = 1'b1;
        send_run(200);
      end
      while (words_sent - phase_start < PhaseWords) send_run(pick_len());
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
